// ===== sv/lfc_pkg.sv =====
`timescale 1ns / 1ps
package lfc_pkg;

  localparam int SEG_COUNT           = 8;
  localparam int SEG_IDX_W           = $clog2(SEG_COUNT);
  localparam int SEG_W               = 16;
  localparam int CNT_W               = 16;
  localparam int LUX_W               = 16;
  localparam int RATIO_FRACTION_BITS = 9;
  localparam int LUX_FRACTION_BITS   = 14;
  localparam int GAIN_SHIFT          = 4;
  localparam int CFG_IDX_W           = 4;
  localparam int CFG_DATA_W          = 3 * SEG_W;

  // ir << (fraction + 1) against (2*breakpoint + 1) * broadband
  localparam int NUM_W  = CNT_W + RATIO_FRACTION_BITS + 1;
  localparam int PROD_W = SEG_W + 1 + CNT_W;

  typedef logic [SEG_IDX_W-1:0] seg_idx_t;

  typedef struct packed {
    logic [SEG_W-1:0] bp;
    logic [SEG_W-1:0] b;
    logic [SEG_W-1:0] m;
  } seg_t;

  typedef struct packed {
    seg_idx_t         idx;
    logic [CNT_W-1:0] bb;
    logic [CNT_W-1:0] ir;
  } sel_t;

  localparam seg_t SEG_RESET [SEG_COUNT] = '{
    48'd274910544318,  48'd549790679761,  48'd824671404923,  48'd1099552523262,
    48'd1340053848572, 48'd1760950354171, 48'd2860449792018, 48'd2860448219136
  };

endpackage

// ===== sv/lfc_ratio.sv =====
`timescale 1ns / 1ps
module lfc_ratio import lfc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CNT_W-1:0] bb_i,
  input  logic [CNT_W-1:0] ir_i,
  input  seg_t             seg_i [SEG_COUNT],
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sel_t             sel_o
);

  localparam int LANES = SEG_COUNT - 1;

  logic              v1_q, v2_q;
  logic              rdy1, rdy2;
  logic [PROD_W-1:0] prod_d [LANES];
  logic [PROD_W-1:0] prod_q [LANES];
  logic [NUM_W-1:0]  num_q;
  logic              bbz_q;
  logic [CNT_W-1:0]  bb1_q, ir1_q;
  sel_t              sel_d, sel_q;

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // one multiplier per breakpoint lane
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      prod_d[i] = PROD_W'({seg_i[i].bp, 1'b1}) * PROD_W'(bb_i);
    end
  end

  // first lane whose breakpoint is not below the ratio wins
  always_comb begin
    sel_d.idx = seg_idx_t'(SEG_COUNT - 1);
    for (int i = LANES - 1; i >= 0; i--) begin
      if (bbz_q || (PROD_W'(num_q) < prod_q[i])) begin
        sel_d.idx = seg_idx_t'(i);
      end
    end
    sel_d.bb = bb1_q;
    sel_d.ir = ir1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      prod_q <= prod_d;
      num_q  <= NUM_W'(ir_i) << (RATIO_FRACTION_BITS + 1);
      bbz_q  <= (bb_i == '0);
      bb1_q  <= bb_i;
      ir1_q  <= ir_i;
    end
    if (rdy2 && v1_q) begin
      sel_q <= sel_d;
    end
  end

  assign out_valid_o = v2_q;
  assign sel_o       = sel_q;

endmodule

// ===== sv/lfc_lux.sv =====
`timescale 1ns / 1ps
module lfc_lux import lfc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sel_t             sel_i,
  input  seg_t             seg_i [SEG_COUNT],
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [LUX_W-1:0] lux_o
);

  localparam int MUL_W = CNT_W + SEG_W;
  localparam int SUM_W = MUL_W + GAIN_SHIFT + 1;

  logic             v3_q, v4_q, v5_q;
  logic             rdy3, rdy4, rdy5;
  seg_t             seg;
  logic [MUL_W-1:0] pos_q, neg_q, diff_q;
  logic [SUM_W-1:0] sum, shifted;
  logic [LUX_W-1:0] lux_d, lux_q;

  assign rdy5       = !v5_q || out_ready_i;
  assign rdy4       = !v4_q || rdy5;
  assign rdy3       = !v3_q || rdy4;
  assign in_ready_o = rdy3;

  assign seg = seg_i[sel_i.idx];

  // apply gain scaling, round half up and saturate
  always_comb begin
    sum     = (SUM_W'(diff_q) << GAIN_SHIFT) + (SUM_W'(1) << (LUX_FRACTION_BITS - 1));
    shifted = sum >> LUX_FRACTION_BITS;
    if (|shifted[SUM_W-1:LUX_W]) begin
      lux_d = '1;
    end else begin
      lux_d = shifted[LUX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy3) v3_q <= in_valid_i;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && in_valid_i) begin
      pos_q <= MUL_W'(sel_i.bb) * MUL_W'(seg.b);
      neg_q <= MUL_W'(sel_i.ir) * MUL_W'(seg.m);
    end
    if (rdy4 && v3_q) begin
      // clamp a negative difference to zero
      diff_q <= (pos_q > neg_q) ? (pos_q - neg_q) : '0;
    end
    if (rdy5 && v4_q) begin
      lux_q <= lux_d;
    end
  end

  assign out_valid_o = v5_q;
  assign lux_o       = lux_q;

endmodule

// ===== sv/lux_from_two_channel_counts.sv =====
`timescale 1ns / 1ps
// Pipeline: lux reaches the output register through five register stages
// after an input transfer.
// Throughput: one count pair per cycle unless the output stalls; seven
// breakpoint lanes and the b/m pair each take one stage; nothing iterates.
// Reset: pipeline empties, segment registers load the standard table.
// A stalled output backs up stage by stage; bubbles still fill behind it.
module lux_from_two_channel_counts import lfc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CNT_W-1:0]      broadband_count_i,
  input  logic [CNT_W-1:0]      infrared_count_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [LUX_W-1:0]      lux_o
);

  seg_t seg_q [SEG_COUNT];
  sel_t sel;
  logic sel_valid, sel_ready;

  // drop writes beyond the last segment
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= SEG_RESET;
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(SEG_COUNT))) begin
      seg_q[cfg_idx_i[SEG_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  lfc_ratio u_ratio (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .bb_i        (broadband_count_i),
    .ir_i        (infrared_count_i),
    .seg_i       (seg_q),
    .out_valid_o (sel_valid),
    .out_ready_i (sel_ready),
    .sel_o       (sel)
  );

  lfc_lux u_lux (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sel_valid),
    .in_ready_o  (sel_ready),
    .sel_i       (sel),
    .seg_i       (seg_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .lux_o       (lux_o)
  );

endmodule

// ===== sv/lfc_checker.sv =====
`timescale 1ns / 1ps
module lfc_checker import lfc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [LUX_W-1:0] lux_o
);

  // an empty output register lets every stage advance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output register empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped before transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(lux_o))
    else $error("lux changed while stalled");

  // the pipeline is empty right after reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result present right after reset");

endmodule

bind lux_from_two_channel_counts lfc_checker u_lfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .lux_o       (lux_o)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import lfc_pkg::*;

  localparam int ITEMS_PER_PHASE = 150;
  localparam int RANDOM_PHASES   = 9;
  localparam int DRAIN_CYCLES    = 20;
  localparam int PROBE_COUNT     = 22;
  localparam logic [LUX_W-1:0] LUX_SAT = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEG_ONE, REG_SEG_TWO, REG_SEG_THREE, REG_SEG_FOUR,
    REG_SEG_FIVE, REG_SEG_SIX, REG_SEG_SEVEN, REG_SEG_EIGHT
  } seg_reg_e;

  typedef enum logic [2:0] {
    CFG_KEEP, CFG_STANDARD, CFG_ALL_ONES, CFG_ALL_ZEROS, CFG_STRAY_INDEX, CFG_RANDOM
  } table_load_e;

  typedef struct packed {
    table_load_e      load;
    logic [CNT_W-1:0] bb;
    logic [CNT_W-1:0] ir;
    logic             typed;
    logic [LUX_W-1:0] lux;
  } probe_row_t;

  // Ratios below assume bb = 4096, where ir = 512 lands exactly on the first breakpoint.
  localparam probe_row_t PROBE_ROWS [PROBE_COUNT] = '{
    '{CFG_STANDARD,    16'd0,     16'd0,     1'b1, 16'd0},
    '{CFG_KEEP,        16'd0,     16'd65535, 1'b1, 16'd0},
    '{CFG_KEEP,        16'd65535, 16'd0,     1'b0, 16'd0},
    '{CFG_KEEP,        16'd4096,  16'd512,   1'b0, 16'd0},
    '{CFG_KEEP,        16'd4096,  16'd520,   1'b0, 16'd0},
    '{CFG_KEEP,        16'd4096,  16'd1024,  1'b0, 16'd0},
    '{CFG_KEEP,        16'd4096,  16'd1536,  1'b0, 16'd0},
    '{CFG_KEEP,        16'd4096,  16'd2048,  1'b0, 16'd0},
    '{CFG_KEEP,        16'd4096,  16'd2560,  1'b0, 16'd0},
    '{CFG_KEEP,        16'd4096,  16'd3072,  1'b0, 16'd0},
    '{CFG_KEEP,        16'd4096,  16'd4096,  1'b0, 16'd0},
    '{CFG_KEEP,        16'd4096,  16'd5632,  1'b1, 16'd0},
    '{CFG_KEEP,        16'd1,     16'd65535, 1'b1, 16'd0},
    '{CFG_KEEP,        16'd65535, 16'd65535, 1'b0, 16'd0},
    '{CFG_STRAY_INDEX, 16'd65535, 16'd0,     1'b0, 16'd0},
    '{CFG_KEEP,        16'd4096,  16'd2048,  1'b0, 16'd0},
    '{CFG_ALL_ONES,    16'd65535, 16'd0,     1'b1, 16'hFFFF},
    '{CFG_KEEP,        16'd0,     16'd65535, 1'b1, 16'd0},
    '{CFG_KEEP,        16'd65535, 16'd65535, 1'b1, 16'd0},
    '{CFG_KEEP,        16'd40000, 16'd39999, 1'b0, 16'd0},
    '{CFG_ALL_ZEROS,   16'd65535, 16'd0,     1'b1, 16'd0},
    '{CFG_KEEP,        16'd0,     16'd0,     1'b1, 16'd0}
  };

  localparam table_load_e PHASE_LOADS [RANDOM_PHASES] = '{
    CFG_STANDARD, CFG_RANDOM, CFG_RANDOM, CFG_ALL_ONES, CFG_RANDOM,
    CFG_STANDARD, CFG_RANDOM, CFG_RANDOM, CFG_RANDOM
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [CNT_W-1:0]      broadband_count_i;
  logic [CNT_W-1:0]      infrared_count_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [LUX_W-1:0]      lux_o;

  seg_t             seg_table [SEG_COUNT];
  logic [LUX_W-1:0] lux_expected_q [$];
  logic [LUX_W-1:0] lux_want;
  int               fail_count;
  int               send_idle_pct;
  int               recv_idle_pct;

  lux_from_two_channel_counts i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .broadband_count_i (broadband_count_i),
    .infrared_count_i  (infrared_count_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .lux_o             (lux_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [LUX_W-1:0] predict_lux(input logic [CNT_W-1:0] bb_cnt,
                                                   input logic [CNT_W-1:0] ir_cnt);
    logic [63:0] bb;
    logic [63:0] ir;
    logic [63:0] ratio;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] diff;
    logic [63:0] rounded;
    seg_t        pick;
    logic        found;
    bb    = 64'(bb_cnt) << GAIN_SHIFT;
    ir    = 64'(ir_cnt) << GAIN_SHIFT;
    ratio = 64'd0;
    if (bb != 0) begin
      ratio = (((ir << (RATIO_FRACTION_BITS + 1)) / bb) + 64'd1) >> 1;
    end
    // First segment whose breakpoint is not below the ratio; the last one catches the rest.
    pick  = seg_table[SEG_COUNT-1];
    found = 1'b0;
    for (int i = 0; i < SEG_COUNT - 1; i++) begin
      if (!found && ratio <= 64'(seg_table[i].bp)) begin
        pick  = seg_table[i];
        found = 1'b1;
      end
    end
    pos     = bb * 64'(pick.b);
    neg     = ir * 64'(pick.m);
    diff    = (pos > neg) ? pos - neg : 64'd0;
    rounded = (diff + (64'd1 << (LUX_FRACTION_BITS - 1))) >> LUX_FRACTION_BITS;
    return (rounded > 64'(LUX_SAT)) ? LUX_SAT : rounded[LUX_W-1:0];
  endfunction

  function automatic seg_t random_segment();
    seg_t seg;
    seg.bp = ($urandom_range(3) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(1100));
    seg.b  = ($urandom_range(3) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(1023));
    seg.m  = ($urandom_range(3) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(1023));
    return seg;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (lux_expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_IDX_W'(idx);
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx < SEG_COUNT) seg_table[idx] = data;
  endtask

  task automatic load_table(input table_load_e load);
    seg_t seg;
    if (load == CFG_KEEP) return;
    wait_drained();
    if (load == CFG_STRAY_INDEX) begin
      // Indexes past the segment registers must leave the table untouched.
      for (int i = SEG_COUNT; i < 2 ** CFG_IDX_W; i++) begin
        write_reg(i, CFG_DATA_W'({$urandom, $urandom}));
      end
    end else begin
      for (int i = REG_SEG_ONE; i <= REG_SEG_EIGHT; i++) begin
        case (load)
          CFG_STANDARD:  seg = SEG_RESET[i];
          CFG_ALL_ONES:  seg = '1;
          CFG_ALL_ZEROS: seg = '0;
          default:       seg = random_segment();
        endcase
        write_reg(i, seg);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_counts(input logic [CNT_W-1:0] bb, input logic [CNT_W-1:0] ir,
                             input logic [LUX_W-1:0] lux);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    broadband_count_i <= bb;
    infrared_count_i  <= ir;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    lux_expected_q.push_back(lux);
  endtask

  task automatic send_random_counts();
    logic [CNT_W-1:0] bb;
    logic [CNT_W-1:0] ir;
    logic [31:0]      scaled;
    case ($urandom_range(9))
      0: begin
        bb = CNT_W'($urandom);
        ir = CNT_W'($urandom);
      end
      1: begin
        bb = ($urandom_range(1)) ? CNT_W'($urandom_range(1)) : ~CNT_W'($urandom_range(1));
        ir = ($urandom_range(1)) ? CNT_W'($urandom_range(1)) : ~CNT_W'($urandom_range(1));
      end
      default: begin
        // Keep ir at most 1600/1024 of broadband so the ratio walks across the breakpoints.
        bb     = CNT_W'($urandom) >> $urandom_range(CNT_W - 1);
        scaled = (32'(bb) * $urandom_range(1600)) >> 10;
        ir     = (scaled > 32'hFFFF) ? '1 : scaled[CNT_W-1:0];
      end
    endcase
    send_counts(bb, ir, predict_lux(bb, ir));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (lux_expected_q.size() == 0) begin
        $error("unexpected lux transfer: lux_o=%0d", lux_o);
        fail_count++;
      end else begin
        lux_want = lux_expected_q.pop_front();
        if (lux_o !== lux_want) begin
          $error("lux mismatch: expected %0d, actual %0d", lux_want, lux_o);
          fail_count++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    broadband_count_i = '0;
    infrared_count_i  = '0;
    out_ready_i       = 1'b0;
    fail_count        = 0;
    send_idle_pct     = 9;
    recv_idle_pct     = 72;
    for (int i = 0; i < SEG_COUNT; i++) seg_table[i] = SEG_RESET[i];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PROBE_ROWS[r]) begin
      load_table(PROBE_ROWS[r].load);
      send_counts(PROBE_ROWS[r].bb, PROBE_ROWS[r].ir,
                  PROBE_ROWS[r].typed ? PROBE_ROWS[r].lux
                                      : predict_lux(PROBE_ROWS[r].bb, PROBE_ROWS[r].ir));
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      load_table(PHASE_LOADS[p]);
      repeat (ITEMS_PER_PHASE) send_random_counts();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && lux_expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lfc_pkg.sv
sv/lfc_ratio.sv
sv/lfc_lux.sv
sv/lux_from_two_channel_counts.sv
sv/lfc_checker.sv
bench/testbench.sv
